// ===== hdl/qte_pkg.sv =====
package qte_pkg;

  localparam int QUAT_FRAC_BITS   = 14;
  localparam int ANGLE_ITERATIONS = 14;
  localparam int ROT_PER_STAGE    = 2;
  localparam int CORDIC_STAGES    = (ANGLE_ITERATIONS + ROT_PER_STAGE - 1) / ROT_PER_STAGE;
  localparam int SQRT_STEPS       = 31;
  localparam int SQRT_PER_STAGE   = 2;
  localparam int SQRT_STAGES      = (SQRT_STEPS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;
  localparam int FRONT_STAGES     = 5;
  localparam int SQ_BASE          = FRONT_STAGES;
  localparam int PRE_STAGE        = SQ_BASE + SQRT_STAGES;
  localparam int CD_BASE          = PRE_STAGE + 1;
  localparam int OUT_STAGE        = CD_BASE + CORDIC_STAGES;
  localparam int NUM_STAGES       = OUT_STAGE + 1;
  localparam int M_SHIFT          = 30 - 2 * QUAT_FRAC_BITS;

  localparam int VW = 37;
  localparam int ZW = 34;
  localparam int SW = 34;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [14:0]   HALF_PI_Q13 = 15'sd12868;
  localparam logic signed [SW-1:0] ONE2        = 34'sd1 <<< (2 * QUAT_FRAC_BITS);

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    vec_t roll;
    vec_t pitch;
    vec_t yaw;
    logic neg;
    logic clamp;
  } cordic_t;

  typedef struct packed {
    logic signed [SW-1:0] roll_x;
    logic signed [SW-1:0] roll_y;
    logic signed [SW-1:0] yaw_x;
    logic signed [SW-1:0] yaw_y;
    logic [29:0]          m;
    logic                 neg;
    logic                 clamp;
  } carry_t;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
    case (i)
      5'd0:    return 34'sd843314856;
      5'd1:    return 34'sd497837829;
      5'd2:    return 34'sd263043836;
      5'd3:    return 34'sd133525158;
      5'd4:    return 34'sd67021686;
      5'd5:    return 34'sd33543515;
      5'd6:    return 34'sd16775850;
      5'd7:    return 34'sd8388437;
      5'd8:    return 34'sd4194282;
      5'd9:    return 34'sd2097149;
      5'd10:   return 34'sd1048575;
      5'd11:   return 34'sd524287;
      5'd12:   return 34'sd262143;
      5'd13:   return 34'sd131071;
      5'd14:   return 34'sd65535;
      5'd15:   return 34'sd32767;
      5'd16:   return 34'sd16383;
      5'd17:   return 34'sd8191;
      5'd18:   return 34'sd4095;
      5'd19:   return 34'sd2047;
      5'd20:   return 34'sd1023;
      5'd21:   return 34'sd511;
      5'd22:   return 34'sd255;
      5'd23:   return 34'sd127;
      default: return '0;
    endcase
  endfunction

  function automatic vec_t prerotate(input logic signed [VW-1:0] x,
                                     input logic signed [VW-1:0] y);
    vec_t r;
    r.zero = (x == '0) && (y == '0);
    r.x    = x;
    r.y    = y;
    r.z    = '0;
    if (x < 0) begin
      if (y >= 0) begin
        r.x = y;
        r.y = -x;
        r.z = HALF_PI_Q30;
      end else begin
        r.x = -y;
        r.y = x;
        r.z = -HALF_PI_Q30;
      end
    end
    return r;
  endfunction

  function automatic vec_t rotate(input vec_t v, input logic [4:0] i);
    vec_t r;
    logic signed [VW-1:0] xs;
    logic signed [VW-1:0] ys;
    r  = v;
    xs = v.x >>> i;
    ys = v.y >>> i;
    if (v.y >= 0) begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.z = v.z + atan_entry(i);
    end else begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.z = v.z - atan_entry(i);
    end
    return r;
  endfunction

  function automatic logic [16:0] round_q13(input logic signed [ZW-1:0] z);
    logic signed [ZW:0] t;
    t = (ZW+1)'(z) + 35'sd65536;
    return t[33:17];
  endfunction

endpackage

// ===== hdl/qte_cordic_stage.sv =====
module qte_cordic_stage
  import qte_pkg::*;
(
  input  logic    clk,
  input  logic    en,
  input  logic [4:0] base,
  input  cordic_t d,
  output cordic_t q
);

  cordic_t nxt;

  always_comb begin
    nxt = d;
    for (int r = 0; r < ROT_PER_STAGE; r++) begin
      if (int'(base) + r < ANGLE_ITERATIONS) begin
        nxt.roll  = rotate(nxt.roll,  5'(int'(base) + r));
        nxt.pitch = rotate(nxt.pitch, 5'(int'(base) + r));
        nxt.yaw   = rotate(nxt.yaw,   5'(int'(base) + r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

// ===== hdl/quaternion_to_euler.sv =====
// Quaternion to Z-Y-X Euler angle converter.
// Slave channel: one unit quaternion per beat, each component signed Q1.14.
// Master channel: roll and yaw in signed Q2.13, pitch in signed Q1.13 radians,
// one beat per input beat, in order; tuser carries the pitch saturation flag.
// Throughput: one beat per cycle while m_tready is high. The depth is set by
// the 31-step square root (two steps per stage) that feeds the pitch arcsine,
// followed by a 14-step CORDIC arctangent (two micro-rotations per stage) that
// runs side by side for all three angles.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse and a stalled receiver only holds the stages that are
// full. s_tready drops only when every stage holds a beat.
// Reset clears all valid bits; no result is pending afterwards. The block
// keeps no state between beats.
module quaternion_to_euler
  import qte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // roll_angle, pitch_angle, yaw_angle, zero pad
  output logic [0:0]  m_tuser    // pitch_clamped
);

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || m_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign s_tready = en[0];

  logic signed [15:0] qw, qx, qy, qz;
  assign qw = s_tdata[15:0];
  assign qx = s_tdata[31:16];
  assign qy = s_tdata[47:32];
  assign qz = s_tdata[63:48];

  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_wz <= qw * qz;
      p_xy <= qx * qy;
      p_zz <= qz * qz;
      p_wy <= qw * qy;
      p_zx <= qz * qx;
    end
  end

  logic signed [SW-1:0] s1_rx, s1_ry, s1_yx, s1_yy, s1_sp;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_ry <= (SW'(p_wx) + SW'(p_yz)) <<< 1;
      s1_rx <= ONE2 - ((SW'(p_xx) + SW'(p_yy)) <<< 1);
      s1_yy <= (SW'(p_wz) + SW'(p_xy)) <<< 1;
      s1_yx <= ONE2 - ((SW'(p_yy) + SW'(p_zz)) <<< 1);
      s1_sp <= (SW'(p_wy) - SW'(p_zx)) <<< 1;
    end
  end

  logic [SW-1:0] s1_mag;
  assign s1_mag = s1_sp[SW-1] ? SW'(-s1_sp) : SW'(s1_sp);

  carry_t s2_c, s3_c, s4_c;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_c.roll_x <= s1_rx;
      s2_c.roll_y <= s1_ry;
      s2_c.yaw_x  <= s1_yx;
      s2_c.yaw_y  <= s1_yy;
      s2_c.neg    <= s1_sp[SW-1];
      s2_c.clamp  <= s1_mag >= SW'(ONE2);
      s2_c.m      <= 30'(s1_mag << M_SHIFT);
    end
  end

  logic [59:0] s3_msq;
  logic [61:0] s4_v;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_c   <= s2_c;
      s3_msq <= s2_c.m * s2_c.m;
    end
    if (en[4]) begin
      s4_c <= s3_c;
      s4_v <= 62'(61'(1) << 60) - 62'(s3_msq);
    end
  end

  logic [32:0] sq_rem  [SQRT_STAGES+1];
  logic [30:0] sq_root [SQRT_STAGES+1];
  logic [61:0] sq_v    [SQRT_STAGES+1];
  carry_t      sq_c    [SQRT_STAGES+1];
  logic [32:0] rem_n   [SQRT_STAGES];
  logic [30:0] root_n  [SQRT_STAGES];
  logic [61:0] v_n     [SQRT_STAGES];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_v[0]    = s4_v;
  assign sq_c[0]    = s4_c;

  always_comb begin
    logic [32:0] r;
    logic [30:0] t;
    logic [61:0] v;
    logic [34:0] sh;
    logic [34:0] trial;
    for (int j = 0; j < SQRT_STAGES; j++) begin
      r = sq_rem[j];
      t = sq_root[j];
      v = sq_v[j];
      for (int s = 0; s < SQRT_PER_STAGE; s++) begin
        if (j * SQRT_PER_STAGE + s < SQRT_STEPS) begin
          sh    = {r, v[61:60]};
          trial = {2'b00, t, 2'b01};
          if (sh >= trial) begin
            sh = sh - trial;
            t  = {t[29:0], 1'b1};
          end else begin
            t  = {t[29:0], 1'b0};
          end
          r = sh[32:0];
          v = v << 2;
        end
      end
      rem_n[j]  = r;
      root_n[j] = t;
      v_n[j]    = v;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < SQRT_STAGES; j++) begin
      if (en[SQ_BASE+j]) begin
        sq_rem[j+1]  <= rem_n[j];
        sq_root[j+1] <= root_n[j];
        sq_v[j+1]    <= v_n[j];
        sq_c[j+1]    <= sq_c[j];
      end
    end
  end

  carry_t               pc;
  logic signed [VW-1:0] s30;
  logic signed [VW-1:0] cos30;
  assign pc    = sq_c[SQRT_STAGES];
  assign s30   = pc.neg ? -$signed({7'b0, pc.m}) : $signed({7'b0, pc.m});
  assign cos30 = $signed({6'b0, sq_root[SQRT_STAGES]});

  cordic_t cd [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (en[PRE_STAGE]) begin
      cd[0].roll  <= prerotate(VW'(pc.roll_x), VW'(pc.roll_y));
      cd[0].yaw   <= prerotate(VW'(pc.yaw_x), VW'(pc.yaw_y));
      cd[0].pitch <= prerotate(cos30, s30);
      cd[0].neg   <= pc.neg;
      cd[0].clamp <= pc.clamp;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cd
    qte_cordic_stage u_stage (
      .clk  (clk),
      .en   (en[CD_BASE+i]),
      .base (5'(i * ROT_PER_STAGE)),
      .d    (cd[i]),
      .q    (cd[i+1])
    );
  end

  cordic_t            fin;
  logic [16:0]        roll_r, pitch_r, yaw_r;
  logic signed [15:0] roll_q, yaw_q;
  logic signed [14:0] pitch_q;
  logic               clamp_q;

  assign fin     = cd[CORDIC_STAGES];
  assign roll_r  = round_q13(fin.roll.z);
  assign pitch_r = round_q13(fin.pitch.z);
  assign yaw_r   = round_q13(fin.yaw.z);

  always_ff @(posedge clk) begin
    if (en[OUT_STAGE]) begin
      roll_q  <= fin.roll.zero ? '0 : roll_r[15:0];
      yaw_q   <= fin.yaw.zero ? '0 : yaw_r[15:0];
      clamp_q <= fin.clamp;
      if (fin.clamp) begin
        pitch_q <= fin.neg ? -HALF_PI_Q13 : HALF_PI_Q13;
      end else begin
        pitch_q <= fin.pitch.zero ? '0 : pitch_r[14:0];
      end
    end
  end

  assign m_tvalid = vld[OUT_STAGE];
  assign m_tdata  = {1'b0, yaw_q, pitch_q, roll_q};
  assign m_tuser  = clamp_q;

  a_clamp_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && clamp_q |-> pitch_q == HALF_PI_Q13 || pitch_q == -HALF_PI_Q13)
    else $error("saturated pitch is not a quarter turn");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted beat did not enter the first stage");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> &vld)
    else $error("input blocked while a stage is empty");

endmodule
